// ----- src/histogram_mode_intensity_standardizer_macros.svh -----
// assertion macros for the histogram mode intensity standardiser
// used by the top level; expects clk and rst_n in scope
`ifndef HISTOGRAM_MODE_INTENSITY_STANDARDIZER_MACROS_SVH
`define HISTOGRAM_MODE_INTENSITY_STANDARDIZER_MACROS_SVH

// same-cycle implication
`define HMIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hmis_pkg.sv -----
// shared types and constants of the histogram mode intensity standardiser
// no dependencies
package hmis_pkg;

  localparam int DIV_NW = 24;
  localparam int DIV_DW = 16;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_MAX   = 3'd1,
    ACT_HIST  = 3'd2,
    ACT_MODE  = 3'd3,
    ACT_MAP   = 3'd4
  } act_t;

  localparam logic [1:0] CFG_REF_MODE = 2'd0;
  localparam logic [1:0] CFG_BG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_NS_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SGO, S_SWAIT, S_EVAL, S_RD, S_WR,
    S_MUL, S_MGO, S_MWAIT, S_WALK, S_WEND, S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

// ----- src/hmis_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module hmis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/hmis_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on hmis_pkg
module hmis_div (
  input  logic                clk,
  input  logic                rst_n,
  input  hmis_pkg::div_req_t  req,
  output hmis_pkg::div_rsp_t  rsp
);
  import hmis_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NW);
        quo_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
endmodule

// ----- src/histogram_mode_intensity_standardizer.sv -----
// Histogram mode intensity standardiser. Items are handled one at a time and each gives one
// result beat. Clear runs a sweep that writes every bin of the count ram; find mode runs a
// walk that reads every bin, one per cycle; histogram and map wait on the shared divider
// that yields one quotient bit per cycle (one division for scaling, one more for a mapped
// brain voxel with a nonzero divisor); histogram and map skip the division with a zero
// peak. After reset a clearing pass over every bin runs before the first item is taken;
// configuration writes are taken at any time. An input beat is taken while the previous
// result still waits in the output register.
// depends on hmis_pkg, hmis_ram, hmis_div and the macros header
module histogram_mode_intensity_standardizer #(
  parameter int BINS       = 255,
  parameter int COUNT_BITS = 24,
  parameter int VOXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // voxel
  input  logic [2:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // scaled_value, standardized_value, mode_bin, peak_raw
  output logic [1:0]  out_tuser,  // is_brain, fault
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import hmis_pkg::*;
  `include "histogram_mode_intensity_standardizer_macros.svh"

  localparam int AW = $clog2(BINS);
  localparam logic [AW-1:0] LAST = AW'(BINS - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [15:0] VMASK = 16'((32'h1 << VOXEL_BITS) - 1);

  state_t state_r, state_nxt;

  logic [7:0]  refm_r, bg_r, nl_r;
  logic [15:0] peak_r;
  logic [7:0]  mode_r;
  logic [2:0]  act_r;
  logic [7:0]  scaled_r, std_r;
  logic        brain_r, fault_r, neg_r, boot_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] dden_r;
  logic [AW-1:0] addr_r, daddr_r, idx_r;
  logic [COUNT_BITS-1:0] best_r;
  logic        rdv_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [1:0]  out_user_r;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        in_acc, out_load, brain;
  logic [15:0] vm;
  logic signed [9:0] dsg;
  logic [7:0]  ma, mb;
  logic        mlo, mneg, mzero;
  logic [DIV_DW-1:0] mden;
  logic [AW-1:0] fidx;
  logic [8:0]  msum;

  hmis_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  hmis_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = state_r == S_IDLE;
  assign in_acc     = in_tvalid && in_tready;
  assign vm         = in_tdata & VMASK;
  assign brain      = (scaled_r > bg_r) && (scaled_r < nl_r);
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign fidx       = (rdv_r && ram_rdata > best_r) ? daddr_r : idx_r;

  // mapping segment selection
  always_comb begin
    dsg   = $signed({2'b00, nl_r}) - 10'sd1 - $signed({2'b00, mode_r});
    mlo   = scaled_r < mode_r;
    mzero = 1'b0;
    if (mlo) begin
      ma   = mode_r - scaled_r;
      mb   = (refm_r > 8'd1) ? refm_r - 8'd1 : 8'd1 - refm_r;
      mden = DIV_DW'(mode_r);
      mneg = refm_r > 8'd1;
    end else begin
      ma    = scaled_r - mode_r;
      mb    = 8'd255 - refm_r;
      mden  = (dsg < 0) ? DIV_DW'(-dsg) : DIV_DW'(dsg);
      mneg  = dsg < 0;
      mzero = dsg == 10'sd0;
    end
    msum = {1'b0, refm_r} + 9'(drsp.quot[7:0]);
  end

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_raddr = addr_r;
    dreq.start = (state_r == S_SGO) || (state_r == S_MGO);
    dreq.num   = num_r;
    dreq.den   = dden_r;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (addr_r == LAST) state_nxt = boot_r ? S_IDLE : S_OUT;
      end
      S_IDLE: begin
        if (in_acc) begin
          priority case (in_tuser)
            ACT_CLEAR: state_nxt = S_CLR;
            ACT_HIST, ACT_MAP: state_nxt = (peak_r == 16'd0) ? S_EVAL : S_SGO;
            ACT_MODE: state_nxt = S_WALK;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SGO: state_nxt = S_SWAIT;
      S_SWAIT: if (drsp.done) state_nxt = S_EVAL;
      S_EVAL: begin
        if (act_r == ACT_HIST) begin
          state_nxt = (brain && 32'(scaled_r) < BINS) ? S_RD : S_OUT;
        end else begin
          state_nxt = brain ? S_MUL : S_OUT;
        end
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        ram_we    = ram_rdata != CMAX;
        ram_wdata = ram_rdata + 1'b1;
        state_nxt = S_OUT;
      end
      S_MUL: state_nxt = mzero ? S_OUT : S_MGO;
      S_MGO: state_nxt = S_MWAIT;
      S_MWAIT: if (drsp.done) state_nxt = S_OUT;
      S_WALK: if (addr_r == LAST) state_nxt = S_WEND;
      S_WEND: state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refm_r <= 8'd0;
      bg_r   <= 8'd9;
      nl_r   <= 8'd254;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_REF_MODE: refm_r <= cfg_wdata;
        CFG_BG_LIMIT: bg_r   <= cfg_wdata;
        CFG_NS_LIMIT: nl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      mode_r <= '0;
      addr_r <= '0;
      boot_r <= 1'b1;
      rdv_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == LAST) boot_r <= 1'b0;
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r    <= in_tuser;
            scaled_r <= '0;
            std_r    <= '0;
            brain_r  <= 1'b0;
            fault_r  <= 1'b0;
            num_r    <= DIV_NW'(vm) * DIV_NW'(255);
            dden_r   <= peak_r;
            addr_r   <= '0;
            rdv_r    <= 1'b0;
            best_r   <= '0;
            idx_r    <= '0;
            priority case (in_tuser)
              ACT_CLEAR: begin
                peak_r <= '0;
                mode_r <= '0;
              end
              ACT_MAX: if (vm > peak_r) peak_r <= vm;
              ACT_HIST, ACT_MAP: if (peak_r == 16'd0) fault_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_SWAIT: begin
          if (drsp.done) begin
            scaled_r <= (drsp.quot > DIV_NW'(255)) ? 8'd255 : drsp.quot[7:0];
          end
        end
        S_EVAL: begin
          std_r   <= scaled_r;
          brain_r <= brain;
          addr_r  <= AW'(scaled_r);
        end
        S_MUL: begin
          num_r  <= DIV_NW'(16'(ma) * 16'(mb));
          dden_r <= mden;
          neg_r  <= mneg;
          if (mzero) begin
            std_r   <= refm_r;
            fault_r <= 1'b1;
          end
        end
        S_MWAIT: begin
          if (drsp.done) begin
            if (neg_r) begin
              std_r <= (drsp.quot > DIV_NW'(refm_r)) ? 8'd0 : refm_r - drsp.quot[7:0];
            end else if (drsp.quot > DIV_NW'(255) || msum > 9'd255) begin
              std_r <= 8'd255;
            end else begin
              std_r <= msum[7:0];
            end
          end
        end
        S_WALK: begin
          if (rdv_r && ram_rdata > best_r) begin
            best_r <= ram_rdata;
            idx_r  <= daddr_r;
          end
          daddr_r <= addr_r;
          rdv_r   <= 1'b1;
          addr_r  <= addr_r + 1'b1;
        end
        S_WEND: mode_r <= 8'(fidx);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {peak_r, mode_r, std_r, scaled_r};
      out_user_r  <= {fault_r, brain_r};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `HMIS_ASSERT_NOW(a_ram_wr_state, ram_we, (state_r == S_CLR) || (state_r == S_WR), "stray ram write")
  `HMIS_ASSERT_NOW(a_inc_nonzero, ram_we && (state_r == S_WR), ram_wdata != '0, "count wrapped")
  `HMIS_ASSERT_NEXT(a_busy_after_acc, in_acc, state_r != S_IDLE, "beat taken without work")
endmodule

// ----- tb/tb_histogram_mode_intensity_standardizer.sv -----
// self-checking testbench of the histogram mode intensity standardiser
// predicts each result beat in a scoreboard class; depends on hmis_pkg and the block
module tb_histogram_mode_intensity_standardizer;
  import hmis_pkg::*;

  typedef struct packed {
    logic [7:0]  scaled;
    logic [7:0]  stdv;
    logic        brain;
    logic [7:0]  mode;
    logic [15:0] peak;
    logic        fault;
  } std_res_t;

  class std_scoreboard;
    logic [7:0]  ref_mode, bg_lim, ns_lim;
    logic [15:0] peak;
    int unsigned counts [255];
    logic [7:0]  in_mode;
    std_res_t    pending [$];
    int          errors;

    function new();
      ref_mode = 8'd0; bg_lim = 8'd9; ns_lim = 8'd254; peak = 16'd0; in_mode = 8'd0;
      errors = 0;
      foreach (counts[i]) counts[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == CFG_REF_MODE) ref_mode = val;
      else if (idx == CFG_BG_LIMIT) bg_lim = val;
      else if (idx == CFG_NS_LIMIT) ns_lim = val;
    endfunction

    function void note_input(logic [2:0] act, logic [15:0] vox);
      std_res_t r;
      longint s, x, mi, ms, d, m;
      int unsigned best;
      int idx;
      r = '0; s = 0;
      if (act == ACT_CLEAR) begin
        peak = 16'd0; in_mode = 8'd0;
        foreach (counts[i]) counts[i] = 0;
      end else if (act == ACT_MAX) begin
        if (vox > peak) peak = vox;
      end else if (act == ACT_HIST || act == ACT_MAP) begin
        if (peak == 0) begin
          r.fault = 1'b1; s = 0;
        end else begin
          s = (255 * longint'(vox)) / longint'(peak);
          if (s > 255) s = 255;
        end
        r.scaled = s[7:0];
        r.brain = (s > longint'(bg_lim)) && (s < longint'(ns_lim));
        r.stdv = s[7:0];
        if (act == ACT_HIST) begin
          if (r.brain && s < 255 && counts[s] < 24'hFFFFFF) counts[s]++;
        end else if (r.brain) begin
          x = s; mi = longint'(in_mode); ms = longint'(ref_mode);
          if (x < mi) m = ms + ((x - mi) * (1 - ms)) / (0 - mi);
          else begin
            d = longint'(ns_lim) - 1 - mi;
            if (d == 0) begin
              r.fault = 1'b1; m = ms;
            end else m = ms + ((x - mi) * (255 - ms)) / d;
          end
          if (m < 0) m = 0;
          if (m > 255) m = 255;
          r.stdv = m[7:0];
        end
      end else if (act == ACT_MODE) begin
        best = counts[0]; idx = 0;
        for (int i = 1; i < 255; i++)
          if (counts[i] > best) begin
            best = counts[i]; idx = i;
          end
        in_mode = idx[7:0];
      end
      r.mode = in_mode;
      r.peak = peak;
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] td, logic [1:0] tu);
      std_res_t e, a;
      a.scaled = td[7:0]; a.stdv = td[15:8]; a.mode = td[23:16]; a.peak = td[39:24];
      a.brain = tu[0]; a.fault = tu[1];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", a);
        return;
      end
      e = pending.pop_front();
      if (a != e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic        clk = 1'b0, rst_n = 1'b0;
  logic        in_tvalid = 1'b0, out_tready = 1'b0, cfg_we = 1'b0;
  logic        in_tready, out_tvalid;
  logic [15:0] in_tdata = 16'd0;
  logic [2:0]  in_tuser = 3'd0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_wdata = 8'd0;

  std_scoreboard sb = new();
  int  hold_off = 0;
  bit  calm = 0;
  bit  recv_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  histogram_mode_intensity_standardizer u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else out_tready <= recv_on && (calm || $urandom_range(99) >= 18);
  end

  // valid stays high after a beat, unless a random gap drops it, so the next beat can follow at once
  task automatic send_voxel(logic [2:0] act, logic [15:0] vox);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tuser <= act; in_tdata <= vox;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, vox);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_voxel(logic [15:0] pk);
    case ($urandom_range(5))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'(pk + $urandom_range(3));
      default: return 16'($urandom_range(pk));
    endcase
  endfunction

  // one volume: clear, peak pass, histogram pass, mode walk, map pass, sometimes a random action
  task automatic run_volume(int n);
    logic [15:0] pk;
    pk = (n < 3) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
    send_voxel(ACT_CLEAR, 16'($urandom));
    send_voxel(ACT_MAX, pk);
    for (int i = 0; i < 4; i++) send_voxel(ACT_MAX, 16'($urandom_range(pk)));
    for (int i = 0; i < n; i++) send_voxel(ACT_HIST, rand_voxel(pk));
    send_voxel(ACT_MODE, 16'($urandom));
    for (int i = 0; i < n; i++) send_voxel(ACT_MAP, rand_voxel(pk));
    if ($urandom_range(3) == 0) send_voxel(3'($urandom_range(7)), 16'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    recv_on = 1;
    // directed: zero peak, empty histogram, undefined actions, extremes
    send_voxel(ACT_HIST, 16'h1234);
    send_voxel(ACT_MAP, 16'hFFFF);
    send_voxel(ACT_MODE, 16'd0);
    send_voxel(3'd5, 16'hFFFF);
    send_voxel(3'd6, 16'd0);
    send_voxel(3'd7, 16'hAAAA);
    send_voxel(ACT_MAX, 16'h0100);
    send_voxel(ACT_HIST, 16'h0080);
    send_voxel(ACT_HIST, 16'h0080);
    send_voxel(ACT_HIST, 16'hFFFF);
    send_voxel(ACT_HIST, 16'd0);
    send_voxel(ACT_MODE, 16'h5555);
    send_voxel(ACT_MAP, 16'h0020);
    send_voxel(ACT_MAP, 16'h00C0);
    send_voxel(ACT_MAP, 16'h0100);
    drain_results();
    // zero upper divisor: noise_limit - 1 equals the mode
    write_reg(CFG_NS_LIMIT, 8'd128);
    send_voxel(ACT_MAP, 16'h0080);
    send_voxel(ACT_MAP, 16'h0070);
    send_voxel(ACT_CLEAR, 16'hFFFF);
    drain_results();
    write_reg(CFG_REF_MODE, 8'd254);
    write_reg(CFG_BG_LIMIT, 8'd0);
    write_reg(CFG_NS_LIMIT, 8'd255);
    run_volume(20);
    drain_results();
    // receiver holds off while the sender keeps going
    hold_off = 300;
    run_volume(30);
    drain_results();
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: begin write_reg(CFG_REF_MODE, 8'd0); write_reg(CFG_BG_LIMIT, 8'd255);
                 write_reg(CFG_NS_LIMIT, 8'd1); end
        1: begin write_reg(CFG_REF_MODE, 8'd127); write_reg(CFG_BG_LIMIT, 8'd9);
                 write_reg(CFG_NS_LIMIT, 8'd254); end
        default: begin
          write_reg(CFG_REF_MODE, 8'($urandom_range(254)));
          write_reg(CFG_BG_LIMIT, 8'($urandom_range(120)));
          write_reg(CFG_NS_LIMIT, 8'($urandom_range(255, 130)));
        end
      endcase
      for (int v = 0; v < 2; v++) run_volume(38);
      drain_results();
    end
    calm = 0;
    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("histogram_mode_intensity_standardizer verification clean");
    else
      $display("histogram_mode_intensity_standardizer verification failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("histogram_mode_intensity_standardizer verification failed");
    $finish;
  end
endmodule
